>>> sv/euler_to_rotation_matrix_defines.svh
// Assertion macros used by the top-level file to check this block.
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, masked while rst is high.
`define E2R_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// Next-cycle implication, masked while rst is high.
`define E2R_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

>>> sv/e2r_pkg.sv
package e2r_pkg;

   localparam int CORDIC_STEPS = 28;
   localparam int QUEUE_DEPTH  = 2;
   // CORDIC stage registers, sine/cosine stage, four arithmetic stages, output.
   localparam int PIPE_DEPTH   = CORDIC_STEPS + 7;

   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   // atan(2^-i) in units of 2^-32 turn.
   localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
      32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
      32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
      32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
      32'sd652, 32'sd326, 32'sd163, 32'sd81,
      32'sd41, 32'sd20, 32'sd10, 32'sd5
   };

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
   } rsp_type;

   // An angle split into its quadrant and the 30-bit turn fraction within it.
   typedef struct packed {
      quad_type    quad;
      logic [29:0] frac;
   } angle_type;

   typedef struct packed {
      angle_type roll;
      angle_type pitch;
      angle_type yaw;
   } item_type;

endpackage

>>> sv/e2r_front.sv
module e2r_front #(
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  e2r_pkg::req_type   req_data,
   output logic               out_valid,
   input  logic               out_ready,
   output e2r_pkg::item_type  out_item
);

   logic              vld_ff;
   logic              vld_in;
   e2r_pkg::item_type item_ff;
   e2r_pkg::item_type item_in;

   // Sign extend, keep the low ANGLE_BITS bits and scale to a 32-bit turn.
   function automatic e2r_pkg::angle_type classify(input logic signed [15:0] a);
      logic signed [31:0] ext;
      logic [31:0]        turn;
      e2r_pkg::angle_type r;
      ext    = 32'(a);
      turn   = 32'(ext) << (32 - ANGLE_BITS);
      r.quad = e2r_pkg::quad_type'(turn[31:30]);
      r.frac = turn[29:0];
      return r;
   endfunction

   assign req_ready = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in.roll  = classify(req_data.roll_angle);
      item_in.pitch = classify(req_data.pitch_angle);
      item_in.yaw   = classify(req_data.yaw_angle);
      vld_in        = req_valid || (vld_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> sv/e2r_queue.sv
module e2r_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  e2r_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output e2r_pkg::item_type  out_item
);

   localparam int PTR_BITS = $clog2(e2r_pkg::QUEUE_DEPTH);

   e2r_pkg::item_type     mem_ff [e2r_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [PTR_BITS:0]     count_ff;
   logic [PTR_BITS:0]     count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff != (PTR_BITS + 1)'(e2r_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(e2r_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(e2r_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> sv/e2r_cordic.sv
module e2r_cordic (
   input  logic                clock,
   input  logic                en,
   input  e2r_pkg::angle_type  angle,
   output logic signed [31:0]  sin_q30,
   output logic signed [31:0]  cos_q30
);

   localparam int N = e2r_pkg::CORDIC_STEPS;

   logic signed [31:0]  x_ff [N+1];
   logic signed [31:0]  y_ff [N+1];
   logic signed [31:0]  z_ff [N+1];
   e2r_pkg::quad_type   q_ff [N+1];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= e2r_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= signed'({2'b00, angle.frac});
         q_ff[0] <= angle.quad;
      end
   end

   // One micro-rotation per stage; the shift amount is fixed by the stage.
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;

      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - e2r_pkg::ATAN_TAB[i];
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + e2r_pkg::ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   always_comb begin
      case (q_ff[N])
         e2r_pkg::QUAD_0: begin
            cos_q30 = x_ff[N];
            sin_q30 = y_ff[N];
         end
         e2r_pkg::QUAD_1: begin
            cos_q30 = -y_ff[N];
            sin_q30 = x_ff[N];
         end
         e2r_pkg::QUAD_2: begin
            cos_q30 = -x_ff[N];
            sin_q30 = -y_ff[N];
         end
         default: begin
            cos_q30 = y_ff[N];
            sin_q30 = -x_ff[N];
         end
      endcase
   end

endmodule

>>> sv/e2r_back.sv
module e2r_back #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_pop,
   input  e2r_pkg::item_type  in_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output e2r_pkg::rsp_type   rsp_data
);

   localparam int D  = e2r_pkg::PIPE_DEPTH;
   localparam int SH = 60 - OUT_FRAC_BITS;
   localparam logic signed [63:0] RND_Q30 = 64'sd1 <<< 29;
   localparam logic signed [63:0] RND_OUT = 64'sd1 <<< (SH - 1);
   localparam logic signed [63:0] LIM     = 64'sd1 <<< OUT_FRAC_BITS;

   logic [D-1:0]        vld_ff;
   logic                en;

   logic signed [31:0]  sr, cr, sp, cp, sy, cy;
   logic signed [31:0]  sr_ff, cr_ff, sp_ff, cp_ff, sy_ff, cy_ff;

   // First multiply stage: ten products of two sine/cosine terms.
   logic signed [63:0]  p_in [10];
   logic signed [63:0]  p_ff [10];
   logic signed [31:0]  sr1_ff, cr1_ff, sp1_ff;

   // Inner products rounded back to 30 fraction bits.
   logic signed [63:0]  t_spcy, t_spsy;
   logic signed [31:0]  spcy_ff, spsy_ff;
   logic signed [63:0]  p2_ff [8];
   logic signed [31:0]  sr2_ff, cr2_ff, sp2_ff;

   logic signed [63:0]  m_in [4];
   logic signed [63:0]  m_ff [4];
   logic signed [63:0]  p3_ff [8];
   logic signed [31:0]  sp3_ff;

   logic signed [63:0]  v_in [9];
   logic signed [63:0]  v_ff [9];

   e2r_pkg::rsp_type    rsp_ff;
   e2r_pkg::rsp_type    rsp_in;

   function automatic logic [15:0] finish(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + RND_OUT) >>> SH;
      if (r > LIM) begin
         r = LIM;
      end
      if (r < -LIM) begin
         r = -LIM;
      end
      return r[15:0];
   endfunction

   // The whole pipeline moves together; it halts only while a result waits.
   assign en        = !vld_ff[D-1] || rsp_ready;
   assign in_pop    = en && in_valid;
   assign rsp_valid = vld_ff[D-1];
   assign rsp_data  = rsp_ff;

   e2r_cordic u_roll  (.clock(clock), .en(en), .angle(in_item.roll),
                       .sin_q30(sr), .cos_q30(cr));
   e2r_cordic u_pitch (.clock(clock), .en(en), .angle(in_item.pitch),
                       .sin_q30(sp), .cos_q30(cp));
   e2r_cordic u_yaw   (.clock(clock), .en(en), .angle(in_item.yaw),
                       .sin_q30(sy), .cos_q30(cy));

   always_comb begin
      p_in[0] = sp_ff * cy_ff;
      p_in[1] = sp_ff * sy_ff;
      p_in[2] = cp_ff * cy_ff;
      p_in[3] = cr_ff * sy_ff;
      p_in[4] = sr_ff * sy_ff;
      p_in[5] = cp_ff * sy_ff;
      p_in[6] = cr_ff * cy_ff;
      p_in[7] = sr_ff * cy_ff;
      p_in[8] = sr_ff * cp_ff;
      p_in[9] = cr_ff * cp_ff;

      t_spcy = (p_ff[0] + RND_Q30) >>> 30;
      t_spsy = (p_ff[1] + RND_Q30) >>> 30;

      m_in[0] = sr2_ff * spcy_ff;
      m_in[1] = cr2_ff * spcy_ff;
      m_in[2] = sr2_ff * spsy_ff;
      m_in[3] = cr2_ff * spsy_ff;

      // p3 holds cpcy, crsy, srsy, cpsy, crcy, srcy, srcp, crcp in order.
      v_in[0] = p3_ff[0];
      v_in[1] = m_ff[0] - p3_ff[1];
      v_in[2] = p3_ff[2] + m_ff[1];
      v_in[3] = p3_ff[3];
      v_in[4] = p3_ff[4] + m_ff[2];
      v_in[5] = m_ff[3] - p3_ff[5];
      v_in[6] = -(64'(sp3_ff) <<< 30);
      v_in[7] = p3_ff[6];
      v_in[8] = p3_ff[7];

      rsp_in.r00 = finish(v_ff[0]);
      rsp_in.r01 = finish(v_ff[1]);
      rsp_in.r02 = finish(v_ff[2]);
      rsp_in.r10 = finish(v_ff[3]);
      rsp_in.r11 = finish(v_ff[4]);
      rsp_in.r12 = finish(v_ff[5]);
      rsp_in.r20 = finish(v_ff[6]);
      rsp_in.r21 = finish(v_ff[7]);
      rsp_in.r22 = finish(v_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[D-2:0], in_valid};
      end
      if (en) begin
         sr_ff <= sr;
         cr_ff <= cr;
         sp_ff <= sp;
         cp_ff <= cp;
         sy_ff <= sy;
         cy_ff <= cy;

         p_ff   <= p_in;
         sr1_ff <= sr_ff;
         cr1_ff <= cr_ff;
         sp1_ff <= sp_ff;

         spcy_ff <= t_spcy[31:0];
         spsy_ff <= t_spsy[31:0];
         for (int k = 0; k < 8; k++) begin
            p2_ff[k] <= p_ff[k+2];
         end
         sr2_ff <= sr1_ff;
         cr2_ff <= cr1_ff;
         sp2_ff <= sp1_ff;

         m_ff   <= m_in;
         p3_ff  <= p2_ff;
         sp3_ff <= sp2_ff;

         v_ff   <= v_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/euler_to_rotation_matrix.sv
// Channel    Direction  Payload             Handshake
// req_       in         e2r_pkg::req_type   req_valid / req_ready
// rsp_       out        e2r_pkg::rsp_type   rsp_valid / rsp_ready
//
// One request and one response transfer per cycle when rsp_ready stays high.
// A request passes the front register, the queue, the CORDIC load register,
// 28 CORDIC stages and six more stages, and then appears as a response.
// The back pipeline halts as a whole while a response waits; the queue keeps
// taking requests until it is full. Reset clears all valid state synchronously.
`include "euler_to_rotation_matrix_defines.svh"

module euler_to_rotation_matrix #(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  e2r_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output e2r_pkg::rsp_type  rsp_data
);

   logic              f_valid;
   logic              f_ready;
   e2r_pkg::item_type f_item;
   logic              q_valid;
   logic              q_pop;
   e2r_pkg::item_type q_item;

   e2r_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   e2r_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_pop), .out_item(q_item)
   );

   e2r_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_pop(q_pop), .in_item(q_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   `E2R_ASSERT_NOW(a_pop_needs_item, clock, reset, q_pop, q_valid)
   `E2R_ASSERT_NEXT(a_front_holds, clock, reset, f_valid && !f_ready, f_valid)
   `E2R_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && !f_valid)

endmodule

>>> dv/tb_euler_to_rotation_matrix.sv
`timescale 1ns / 1ps

module tb_euler_to_rotation_matrix;

   localparam int ANGLE_W   = 16;
   localparam int FRAC_OUT  = 14;
   localparam int N_STEPS   = 28;
   localparam int LATENCY   = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   e2r_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   e2r_pkg::rsp_type rsp_data;

   e2r_pkg::rsp_type matrix_queue[$];
   int      error_count = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   euler_to_rotation_matrix u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Arithmetic shift right that floors, as the datapath does.
   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint cordic_angle(int k);
      longint tab[N_STEPS];
      tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
              41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
              10, 5};
      return tab[k];
   endfunction

   function automatic void sin_cos(input logic [15:0] raw, output longint s,
                                   output longint c);
      logic [31:0]       turn;
      longint            x, y, z, dx, dy;
      e2r_pkg::quad_type quad;
      turn = 32'(raw) << (32 - ANGLE_W);
      quad = e2r_pkg::quad_type'(turn[31:30]);
      z = longint'(turn[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < N_STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= cordic_angle(i);
         end else begin
            x += dx; y -= dy; z += cordic_angle(i);
         end
      end
      case (quad)
         e2r_pkg::QUAD_0: begin c = x;  s = y;  end
         e2r_pkg::QUAD_1: begin c = -y; s = x;  end
         e2r_pkg::QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic signed [15:0] round_entry(longint v60);
      longint lim, r;
      lim = longint'(1) <<< FRAC_OUT;
      r = floor_shift(v60 + (longint'(1) <<< (59 - FRAC_OUT)), 60 - FRAC_OUT);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   function automatic longint mul_round30(longint a, longint b);
      return floor_shift(a * b + (longint'(1) <<< 29), 30);
   endfunction

   function automatic e2r_pkg::rsp_type rotation_of(e2r_pkg::req_type a);
      longint           sr, cr, sp, cp, sy, cy, spcy, spsy;
      e2r_pkg::rsp_type m;
      sin_cos(a.roll_angle, sr, cr);
      sin_cos(a.pitch_angle, sp, cp);
      sin_cos(a.yaw_angle, sy, cy);
      spcy = mul_round30(sp, cy);
      spsy = mul_round30(sp, sy);
      m.r00 = round_entry(cp * cy);
      m.r01 = round_entry(-(cr * sy) + sr * spcy);
      m.r02 = round_entry(sr * sy + cr * spcy);
      m.r10 = round_entry(cp * sy);
      m.r11 = round_entry(cr * cy + sr * spsy);
      m.r12 = round_entry(-(sr * cy) + cr * spsy);
      m.r20 = round_entry(-sp * (longint'(1) <<< 30));
      m.r21 = round_entry(sr * cp);
      m.r22 = round_entry(cr * cp);
      return m;
   endfunction

   // Valid stays high from one transfer to the next unless an idle cycle is drawn.
   task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                              input logic [15:0] yaw);
      e2r_pkg::req_type a;
      a.roll_angle  = roll;
      a.pitch_angle = pitch;
      a.yaw_angle   = yaw;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= a;
      do @(posedge clock); while (!req_ready);
      matrix_queue.push_back(rotation_of(a));
      sent_count++;
   endtask

   task automatic report_entry(input string name, input logic signed [15:0] e,
                               input logic signed [15:0] a);
      $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      error_count++;
   endtask

   // Receiver stall pattern, redrawn at each falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      e2r_pkg::rsp_type exp_m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (matrix_queue.size() == 0) begin
            $display("%0t: unexpected matrix transfer %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_m = matrix_queue.pop_front();
            checked_count++;
            if (exp_m.r00 !== rsp_data.r00) report_entry("r00", exp_m.r00, rsp_data.r00);
            if (exp_m.r01 !== rsp_data.r01) report_entry("r01", exp_m.r01, rsp_data.r01);
            if (exp_m.r02 !== rsp_data.r02) report_entry("r02", exp_m.r02, rsp_data.r02);
            if (exp_m.r10 !== rsp_data.r10) report_entry("r10", exp_m.r10, rsp_data.r10);
            if (exp_m.r11 !== rsp_data.r11) report_entry("r11", exp_m.r11, rsp_data.r11);
            if (exp_m.r12 !== rsp_data.r12) report_entry("r12", exp_m.r12, rsp_data.r12);
            if (exp_m.r20 !== rsp_data.r20) report_entry("r20", exp_m.r20, rsp_data.r20);
            if (exp_m.r21 !== rsp_data.r21) report_entry("r21", exp_m.r21, rsp_data.r21);
            if (exp_m.r22 !== rsp_data.r22) report_entry("r22", exp_m.r22, rsp_data.r22);
         end
      end
   end

   task automatic test_directed();
      logic [15:0] corner[8];
      corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001,
                 16'h2000, 16'hFFFF};
      // Quadrant boundaries and extremes on each axis in turn.
      foreach (corner[i]) send_angles(corner[i], 16'h0000, 16'h0000);
      foreach (corner[i]) send_angles(16'h0000, corner[i], 16'h0000);
      foreach (corner[i]) send_angles(16'h0000, 16'h0000, corner[i]);
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      logic [15:0] p;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         // Some pitches sit next to the quarter turns, where saturation can bite.
         p = ($urandom_range(3) == 0) ? (16'h4000 ^ 16'($urandom_range(7)))
                                      : 16'($urandom);
         if ($urandom_range(1)) p = -p;
         send_angles(16'($urandom), p, 16'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 0, 0);
      test_random(600, 48, 0);
      test_random(600, 0, 48);
      test_random(500, 25, 25);
      @(negedge clock);
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      $display("Sent %0d angle triples and checked %0d matrices,", sent_count,
               checked_count);
      $display("with and without sender gaps and receiver stalls.");
      if (error_count == 0 && matrix_queue.size() == 0) begin
         $display("tb_euler_to_rotation_matrix passed");
      end else begin
         $display("tb_euler_to_rotation_matrix failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_euler_to_rotation_matrix failed");
      $finish;
   end

endmodule
